// ===== design/xdnp_pkg.sv =====
`default_nettype none

package xdnp_pkg;

	// widths of the item fields
	localparam int unsigned COORD_W = 12;
	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned STRENGTH_W = 10;
	localparam int unsigned INDEX_W = 8;

	// pattern arithmetic only needs the low nine bits of every term
	localparam int unsigned PAT_W = 9;
	localparam int unsigned PAT_MOD = 1 << PAT_W;
	localparam int unsigned PAT_X_STEP = 29;
	localparam int unsigned PAT_Y_MUL = 149;
	localparam int unsigned PAT_MUL = 1234 % PAT_MOD;
	localparam int unsigned PAT_MID = PAT_MOD / 2;

	// strength is in units of 1/256, offset divides by 2048
	localparam int unsigned SCALE_SHIFT = 11;
	localparam int unsigned PROD_W = PAT_W + STRENGTH_W;
	localparam int unsigned OFFSET_W = PROD_W - SCALE_SHIFT;

	localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = STRENGTH_W'(26);

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRENGTH = 2'd0,
		REG_KEY_EN   = 2'd1,
		REG_KEY_IDX  = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== design/xdnp_lane.sv =====
`default_nettype none

module xdnp_lane import xdnp_pkg::*; #(
	parameter int unsigned LANE = 0
) (
	input  wire logic                  clk,
	input  wire logic [COORD_W-1:0]    column,
	input  wire logic [COORD_W-1:0]    row,
	input  wire logic [SAMPLE_W-1:0]   sample,
	input  wire logic [STRENGTH_W-1:0] strength,
	output logic      [SAMPLE_W-1:0]   result
);

	localparam logic [PAT_W-1:0] X_OFS = PAT_W'((PAT_X_STEP * LANE) % PAT_MOD);
	localparam logic [PAT_W-1:0] Y_MUL = PAT_W'(PAT_Y_MUL);
	localparam logic [PAT_W-1:0] N_MUL = PAT_W'(PAT_MUL);
	localparam logic [PAT_W-1:0] MID = PAT_W'(PAT_MID);

	logic [PAT_W-1:0]    pat_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [PAT_W-1:0]    mag_s2;
	logic                neg_s2;
	logic [SAMPLE_W-1:0] sample_s2;
	logic [OFFSET_W-1:0] ofs_s3;
	logic                neg_s3;
	logic [SAMPLE_W-1:0] sample_s3;

	logic [PAT_W-1:0]    x_term;
	logic [PAT_W-1:0]    y_term;
	logic [PAT_W-1:0]    n_val;
	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W:0]   sum;

	// stage 1: column and row terms, mod 512
	assign x_term = column[PAT_W-1:0] + X_OFS;
	assign y_term = PAT_W'(row[PAT_W-1:0] * Y_MUL);

	always_ff @(posedge clk) begin
		pat_s1    <= x_term ^ y_term;
		sample_s1 <= sample;
	end

	// stage 2: pattern value and its distance from the midpoint
	assign n_val = PAT_W'(pat_s1 * N_MUL);

	always_ff @(posedge clk) begin
		neg_s2    <= (n_val < MID);
		mag_s2    <= (n_val < MID) ? (MID - n_val) : (n_val - MID);
		sample_s2 <= sample_s1;
	end

	// stage 3: scale magnitude by strength, drop the fraction
	assign prod = PROD_W'(mag_s2) * PROD_W'(strength);

	always_ff @(posedge clk) begin
		ofs_s3    <= prod[PROD_W-1:SCALE_SHIFT];
		neg_s3    <= neg_s2;
		sample_s3 <= sample_s2;
	end

	// apply signed offset and clamp to the sample range
	always_comb begin
		if (neg_s3) begin
			sum = {1'b0, sample_s3} - (SAMPLE_W+1)'(ofs_s3);
			result = (sample_s3 < SAMPLE_W'(ofs_s3)) ? '0 : sum[SAMPLE_W-1:0];
		end else begin
			sum = {1'b0, sample_s3} + (SAMPLE_W+1)'(ofs_s3);
			result = sum[SAMPLE_W] ? '1 : sum[SAMPLE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== design/x_dither_noise_perturb.sv =====
`default_nettype none

// pattern noise perturbation for the x-dither quantizer
// input: one pixel per start pulse (column, band row, four samples, mask bit);
// the block never holds off a pixel, so busy stays low and a pixel may be
// given on every clock
// output: each pixel produces one result after the lane stages and the output register,
// marked by a one-cycle done strobe; results come out in input order
// throughput: one pixel per clock, set by the four-stage pipeline
// (pattern xor, pattern multiply, strength multiply, add and clamp)
// the receiver cannot stall: a result is there for the done cycle only
// configuration: cfg_valid/cfg_ready write channel, always ready; index 0
// strength, 1 key enable, 2 key index, other indexes ignored; write only
// while no pixel is in flight
// reset: clears the pipeline valid bits and restores strength 26, keying off
// channels at or above CHANNELS read as zero; a keyed transparent pixel
// gives all-zero samples with forced set and the key index

module x_dither_noise_perturb import xdnp_pkg::*; #(
	parameter int unsigned CHANNELS = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [COORD_W-1:0]   column,
	input  wire logic [COORD_W-1:0]   row,
	input  wire logic [SAMPLE_W-1:0]  chan_a,
	input  wire logic [SAMPLE_W-1:0]  chan_b,
	input  wire logic [SAMPLE_W-1:0]  chan_c,
	input  wire logic [SAMPLE_W-1:0]  chan_d,
	input  wire logic                 mask_bit,
	output logic                      done,
	output logic      [SAMPLE_W-1:0]  out_a,
	output logic      [SAMPLE_W-1:0]  out_b,
	output logic      [SAMPLE_W-1:0]  out_c,
	output logic      [SAMPLE_W-1:0]  out_d,
	output logic                      forced,
	output logic      [INDEX_W-1:0]   forced_index,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [STRENGTH_W-1:0] cfg_data
);

	localparam int unsigned CH_USED = (CHANNELS > 4) ? 4 : ((CHANNELS < 1) ? 1 : CHANNELS);
	localparam int unsigned LANES = 4;

	logic [STRENGTH_W-1:0] strength_q;
	logic                  key_en_q;
	logic [INDEX_W-1:0]    key_idx_q;

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  forced_s1, forced_s2, forced_s3;
	logic                  accept;

	logic [SAMPLE_W-1:0]   samples [LANES];
	logic [SAMPLE_W-1:0]   lane_res [LANES];
	logic [SAMPLE_W-1:0]   res_s4 [LANES];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	assign samples[0] = chan_a;
	assign samples[1] = chan_b;
	assign samples[2] = chan_c;
	assign samples[3] = chan_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= STRENGTH_RESET;
			key_en_q   <= 1'b0;
			key_idx_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STRENGTH: strength_q <= cfg_data;
				REG_KEY_EN:   key_en_q   <= cfg_data[0];
				REG_KEY_IDX:  key_idx_q  <= cfg_data[INDEX_W-1:0];
				default:      ;
			endcase
		end
	end

	// valid bits and key decision travel beside the lane data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		forced_s1 <= key_en_q && mask_bit;
		forced_s2 <= forced_s1;
		forced_s3 <= forced_s2;
	end

	// one lane per used channel, unused lanes read as zero
	for (genvar c = 0; c < LANES; c++) begin : g_lane
		if (c < CH_USED) begin : g_used
			xdnp_lane #(
				.LANE(c)
			) u_lane (
				.clk      (clk),
				.column   (column),
				.row      (row),
				.sample   (samples[c]),
				.strength (strength_q),
				.result   (lane_res[c])
			);
		end else begin : g_unused
			assign lane_res[c] = '0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			res_s4[i] <= forced_s3 ? '0 : lane_res[i];
		end
		forced       <= forced_s3;
		forced_index <= forced_s3 ? key_idx_q : '0;
	end

	assign out_a = res_s4[0];
	assign out_b = res_s4[1];
	assign out_c = res_s4[2];
	assign out_d = res_s4[3];

	// each taken pixel gives a result strobe on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("result strobe missing four cycles after a pixel");

	// a keyed pixel carries no samples
	a_forced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && forced) |-> (out_a == '0 && out_b == '0 && out_c == '0 && out_d == '0))
		else $error("keyed pixel has nonzero samples");

	// key index only shows on keyed pixels
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !forced) |-> (forced_index == '0))
		else $error("key index on a pixel that was not keyed");

	// fourth channel is silent when not in use
	a_unused_d: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (CH_USED < LANES)) |-> (out_d == '0))
		else $error("unused channel carries data");

endmodule

`default_nettype wire

// ===== dv/tb_x_dither_noise_perturb.sv =====
`default_nettype none

module tb_x_dither_noise_perturb;
	import xdnp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_CH = 3;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned RAND_PHASES = 11;
	localparam int unsigned PHASE_PIXELS = 139;
	// index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0]           column;
		logic [COORD_W-1:0]           row;
		logic [3:0][SAMPLE_W-1:0]     samp;
		logic                         mask;
	} pixel_t;

	typedef struct packed {
		logic [3:0][SAMPLE_W-1:0]     samp;
		logic                         forced;
		logic [INDEX_W-1:0]           index;
	} pix_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [COORD_W-1:0]    column = '0;
	logic [COORD_W-1:0]    row = '0;
	logic [SAMPLE_W-1:0]   chan_a = '0;
	logic [SAMPLE_W-1:0]   chan_b = '0;
	logic [SAMPLE_W-1:0]   chan_c = '0;
	logic [SAMPLE_W-1:0]   chan_d = '0;
	logic                  mask_bit = 1'b0;
	logic                  done;
	logic [SAMPLE_W-1:0]   out_a;
	logic [SAMPLE_W-1:0]   out_b;
	logic [SAMPLE_W-1:0]   out_c;
	logic [SAMPLE_W-1:0]   out_d;
	logic                  forced;
	logic [INDEX_W-1:0]    forced_index;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [STRENGTH_W-1:0] cfg_data = '0;

	// predictor copy of the registers
	logic [STRENGTH_W-1:0] model_strength;
	logic                  model_key_en;
	logic [INDEX_W-1:0]    model_key_idx;

	pix_result_t expected_pixels[$];
	pix_result_t want;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_max = 10;

	x_dither_noise_perturb #(
		.CHANNELS(NUM_CH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.column(column),
		.row(row),
		.chan_a(chan_a),
		.chan_b(chan_b),
		.chan_c(chan_c),
		.chan_d(chan_d),
		.mask_bit(mask_bit),
		.done(done),
		.out_a(out_a),
		.out_b(out_b),
		.out_c(out_c),
		.out_d(out_d),
		.forced(forced),
		.forced_index(forced_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected result of one pixel under the current registers
	function automatic pix_result_t predict_pixel(pixel_t p);
		pix_result_t r;
		int unsigned used;
		int unsigned n;
		int unsigned mag;
		int offs;
		int v;
		r = '0;
		if (model_key_en && p.mask) begin
			r.forced = 1'b1;
			r.index = model_key_idx;
			return r;
		end
		used = (NUM_CH > 4) ? 4 : ((NUM_CH < 1) ? 1 : NUM_CH);
		for (int c = 0; c < 4; c++) begin
			if (c < used) begin
				n = (((32'(p.column) + 32'(29 * c)) ^ (32'd149 * 32'(p.row))) * 32'd1234)
					& 32'd511;
				if (n < 256) begin
					mag = 256 - n;
					offs = -int'((mag * model_strength) >> 11);
				end else begin
					mag = n - 256;
					offs = int'((mag * model_strength) >> 11);
				end
				v = int'(p.samp[c]) + offs;
				if (v < 0)
					v = 0;
				else if (v > 255)
					v = 255;
				r.samp[c] = 8'(v);
			end
		end
		return r;
	endfunction

	function automatic pixel_t make_pixel(int unsigned col, int unsigned rw, int unsigned a,
			int unsigned b, int unsigned c, int unsigned d, int unsigned m);
		pixel_t p;
		p.column = COORD_W'(col);
		p.row = COORD_W'(rw);
		p.samp[0] = SAMPLE_W'(a);
		p.samp[1] = SAMPLE_W'(b);
		p.samp[2] = SAMPLE_W'(c);
		p.samp[3] = SAMPLE_W'(d);
		p.mask = m[0];
		return p;
	endfunction

	// samples biased toward both clamp limits
	function automatic int unsigned rand_sample();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return $urandom_range(240, 255);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic int unsigned rand_coord();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 4095;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	// send one pixel, then hold off a random number of cycles
	task automatic send_pixel(pixel_t p);
		int unsigned gap;
		column <= p.column;
		row <= p.row;
		chan_a <= p.samp[0];
		chan_b <= p.samp[1];
		chan_c <= p.samp[2];
		chan_d <= p.samp[3];
		mask_bit <= p.mask;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_pixels.push_back(predict_pixel(p));
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait for every pending result
	task automatic wait_pipeline_empty();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_pixels.size() != 0);
	endtask

	// one register write; valid stays high for a following write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STRENGTH_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_STRENGTH: model_strength = data;
			REG_KEY_EN:   model_key_en = data[0];
			REG_KEY_IDX:  model_key_idx = data[INDEX_W-1:0];
			default: ;
		endcase
	endtask

	task automatic close_cfg();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// all three registers, unused data bits filled at random
	task automatic set_config(int unsigned str, int unsigned en, int unsigned idx);
		write_reg(REG_STRENGTH, STRENGTH_W'(str));
		write_reg(REG_KEY_EN, {9'($urandom), en[0]});
		write_reg(REG_KEY_IDX, {2'($urandom), idx[7:0]});
		close_cfg();
	endtask

	task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			error_count++;
		end
	endtask

	// compare every result with the oldest pending pixel
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: result with no pixel pending, expected none, actual %h",
					$time, {out_a, out_b, out_c, out_d, forced, forced_index});
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("out_a", want.samp[0], out_a);
				check_field("out_b", want.samp[1], out_b);
				check_field("out_c", want.samp[2], out_c);
				check_field("out_d", want.samp[3], out_d);
				check_field("forced", {7'd0, want.forced}, {7'd0, forced});
				check_field("forced_index", want.index, forced_index);
			end
		end
	end

	// reset values: default strength, keying off so mask is ignored
	task automatic test_reset_values();
		send_pixel(make_pixel(0, 0, 128, 128, 128, 128, 0));
		send_pixel(make_pixel(100, 7, 10, 245, 0, 255, 1));
		send_pixel(make_pixel(4095, 4095, 255, 0, 200, 9, 1));
		wait_pipeline_empty();
	endtask

	// full strength, coordinate and sample extremes, both clamp limits
	task automatic test_field_extremes();
		set_config(1023, 0, 0);
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(4095, 4095, 255, 255, 255, 255, 1));
		send_pixel(make_pixel(0, 4095, 0, 255, 0, 255, 1));
		send_pixel(make_pixel(4095, 0, 255, 0, 255, 0, 0));
		send_pixel(make_pixel(2048, 2048, 128, 127, 1, 254, 0));
		send_pixel(make_pixel(1, 1, 3, 252, 64, 191, 0));
		send_pixel(make_pixel(4038, 4094, 0, 0, 255, 255, 1));
		send_pixel(make_pixel(2730, 1365, 255, 255, 0, 0, 0));
		wait_pipeline_empty();
	endtask

	// zero strength passes samples through
	task automatic test_zero_strength();
		set_config(0, 0, 0);
		send_pixel(make_pixel(777, 333, 0, 255, 17, 99, 0));
		send_pixel(make_pixel(4095, 4095, 255, 0, 128, 1, 1));
		wait_pipeline_empty();
	endtask

	// keyed transparent pixels and opaque pixels with keying on
	task automatic test_keying();
		set_config(26, 1, 255);
		send_pixel(make_pixel(5, 6, 100, 100, 100, 100, 1));
		send_pixel(make_pixel(5, 6, 100, 100, 100, 100, 0));
		send_pixel(make_pixel(4095, 4095, 255, 255, 255, 255, 1));
		wait_pipeline_empty();
		set_config(512, 1, 0);
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 1));
		send_pixel(make_pixel(300, 12, 250, 3, 128, 77, 0));
		send_pixel(make_pixel(1234, 4000, 9, 9, 9, 9, 1));
		wait_pipeline_empty();
	endtask

	// write to an unmapped index leaves every register as it was
	task automatic test_unknown_register();
		set_config(700, 1, 8'hA5);
		write_reg(REG_UNUSED, 10'h3FF);
		write_reg(REG_UNUSED, STRENGTH_W'($urandom));
		close_cfg();
		send_pixel(make_pixel(64, 65, 30, 220, 140, 0, 1));
		send_pixel(make_pixel(3000, 2999, 255, 0, 1, 2, 0));
		wait_pipeline_empty();
	endtask

	// phases of random pixels, each under its own register setting
	task automatic test_random_traffic();
		int unsigned str;
		int unsigned en;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: str = 1023;
				1: str = 0;
				2: str = 26;
				3: str = 1;
				default: str = $urandom_range(0, 1023);
			endcase
			en = (ph < 4) ? (ph % 2) : $urandom_range(0, 1);
			set_config(str, en, $urandom_range(0, 255));
			// every third phase runs back to back
			gap_max = (ph % 3 == 0) ? 0 : 10;
			for (int i = 0; i < PHASE_PIXELS; i++)
				send_pixel(make_pixel(rand_coord(), rand_coord(), rand_sample(), rand_sample(),
					rand_sample(), rand_sample(), ($urandom_range(0, 9) < 3) ? 1 : 0));
			wait_pipeline_empty();
		end
		gap_max = 10;
	endtask

	// run watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// test sequence
	initial begin
		model_strength = STRENGTH_W'(26);
		model_key_en = 1'b0;
		model_key_idx = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_field_extremes();
		test_zero_strength();
		test_keying();
		test_unknown_register();
		test_random_traffic();
		wait_pipeline_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			$display("%0t: pixels left without result, expected 0, actual %0d", $time,
				expected_pixels.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/xdnp_pkg.sv
design/xdnp_lane.sv
design/x_dither_noise_perturb.sv
dv/tb_x_dither_noise_perturb.sv
